[rtl/vhs_pkg.sv]
// Shared types and constants for the 2x2x2 volume halving block.
`timescale 1ns / 1ps
package vhs_pkg;

    // Largest volume row and column counts the cube store covers.
    localparam int MAX_WIDTH   = 512;
    localparam int MAX_HEIGHT  = 512;
    localparam int HALF_W      = MAX_WIDTH / 2;

    // Cube store geometry.
    localparam int STORE_DEPTH = 65536;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int ACC_W       = 11;
    localparam int SUM_LIMIT   = 2047;

    // Field and counter widths.
    localparam int VOX_W       = 8;
    localparam int COL_W       = 10;
    localparam int ROW_W       = 10;
    localparam int PLANE_W     = 12;
    localparam int CHAN_W      = 2;
    localparam int DEPTH_W     = 13;
    localparam int NCH_W       = 3;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 3;

    localparam int DEPTH_LIMIT = 4096;
    localparam int CH_LIMIT    = 4;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_MODE_MAX     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOL_WIDTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VOL_HEIGHT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VOL_DEPTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_CHANNELS = 3'd4;

    typedef struct packed {
        logic               mode_max;
        logic [COL_W-1:0]   vol_width;
        logic [ROW_W-1:0]   vol_height;
        logic [DEPTH_W-1:0] vol_depth;
        logic [NCH_W-1:0]   num_channels;
    } cfg_t;

    // Per-item cube bookkeeping handed from the scan counters to the accumulator.
    typedef struct packed {
        logic             act;       // voxel lies inside a full cube
        logic             first;     // first voxel of its cube
        logic             last;      // last voxel of its cube
        logic             out_last;  // final result of the last channel
        logic [IDX_W-1:0] idx;       // cube store entry
    } cube_info_t;

endpackage

[rtl/vhs_ram.sv]
// Generic single-write, single-read RAM with registered read (read-first).
`timescale 1ns / 1ps
module vhs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/vhs_scan.sv]
// Raster position counters and cube classification of the incoming voxel.
`timescale 1ns / 1ps
module vhs_scan (
    input  logic                aclk,
    input  logic                aresetn,
    input  vhs_pkg::cfg_t       cfg,
    input  logic                advance,
    output vhs_pkg::cube_info_t info
);

    logic [vhs_pkg::COL_W-1:0]   col_reg,   col_next;
    logic [vhs_pkg::ROW_W-1:0]   row_reg,   row_next;
    logic [vhs_pkg::PLANE_W-1:0] plane_reg, plane_next;
    logic [vhs_pkg::CHAN_W-1:0]  chan_reg,  chan_next;

    logic [vhs_pkg::COL_W-1:0]   ucols;
    logic [vhs_pkg::ROW_W-1:0]   urows;
    logic [vhs_pkg::DEPTH_W-1:0] eff_depth;
    logic [vhs_pkg::DEPTH_W-1:0] uplanes;
    logic [vhs_pkg::NCH_W-1:0]   eff_ch;

    logic [vhs_pkg::COL_W:0]     col_inc;
    logic [vhs_pkg::ROW_W:0]     row_inc;
    logic [vhs_pkg::DEPTH_W-1:0] plane_inc;
    logic [vhs_pkg::NCH_W-1:0]   chan_inc;

    // Usable (even, capped) extents.
    always_comb begin
        ucols = (cfg.vol_width < vhs_pkg::COL_W'(vhs_pkg::MAX_WIDTH))
              ? cfg.vol_width : vhs_pkg::COL_W'(vhs_pkg::MAX_WIDTH);
        ucols[0] = 1'b0;
        urows = (cfg.vol_height < vhs_pkg::ROW_W'(vhs_pkg::MAX_HEIGHT))
              ? cfg.vol_height : vhs_pkg::ROW_W'(vhs_pkg::MAX_HEIGHT);
        urows[0] = 1'b0;
        eff_depth = (cfg.vol_depth > vhs_pkg::DEPTH_W'(vhs_pkg::DEPTH_LIMIT))
                  ? vhs_pkg::DEPTH_W'(vhs_pkg::DEPTH_LIMIT) : cfg.vol_depth;
        uplanes = eff_depth;
        uplanes[0] = 1'b0;
        if (cfg.num_channels == '0) begin
            eff_ch = vhs_pkg::NCH_W'(1);
        end else if (cfg.num_channels > vhs_pkg::NCH_W'(vhs_pkg::CH_LIMIT)) begin
            eff_ch = vhs_pkg::NCH_W'(vhs_pkg::CH_LIMIT);
        end else begin
            eff_ch = cfg.num_channels;
        end
    end

    always_comb begin
        col_inc   = {1'b0, col_reg} + 1'b1;
        row_inc   = {1'b0, row_reg} + 1'b1;
        plane_inc = {1'b0, plane_reg} + 1'b1;
        chan_inc  = {1'b0, chan_reg} + 1'b1;

        info.act = (col_reg < ucols) && (row_reg < urows)
                && ({1'b0, plane_reg} < uplanes);
        info.first = ~(col_reg[0] | row_reg[0] | plane_reg[0]);
        info.last  =   col_reg[0] & row_reg[0] & plane_reg[0];
        info.out_last = (chan_inc == eff_ch) && (plane_inc == uplanes)
                     && (row_inc == {1'b0, urows}) && (col_inc == {1'b0, ucols});
        info.idx = vhs_pkg::IDX_W'(32'(row_reg >> 1) * vhs_pkg::HALF_W
                                 + 32'(col_reg >> 1));

        // Column carries into row, row into plane, plane into channel.
        col_next   = col_inc[vhs_pkg::COL_W-1:0];
        row_next   = row_reg;
        plane_next = plane_reg;
        chan_next  = chan_reg;
        if (col_inc >= {1'b0, cfg.vol_width}) begin
            col_next = '0;
            row_next = row_inc[vhs_pkg::ROW_W-1:0];
            if (row_inc >= {1'b0, cfg.vol_height}) begin
                row_next   = '0;
                plane_next = plane_inc[vhs_pkg::PLANE_W-1:0];
                if (plane_inc >= eff_depth) begin
                    plane_next = '0;
                    chan_next  = chan_inc[vhs_pkg::CHAN_W-1:0];
                    if (chan_inc >= eff_ch) begin
                        chan_next = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            plane_reg <= '0;
            chan_reg  <= '0;
        end else if (advance) begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            plane_reg <= plane_next;
            chan_reg  <= chan_next;
        end
    end

endmodule

[rtl/vhs_accum.sv]
// Read-modify-write stage on the cube store plus the result register.
`timescale 1ns / 1ps
module vhs_accum (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            mode_max,
    input  logic                            in_take,
    input  vhs_pkg::cube_info_t             in_info,
    input  logic [vhs_pkg::VOX_W-1:0]       in_voxel,
    output logic                            in_ready,
    input  logic [vhs_pkg::ACC_W-1:0]       rd_data,
    output logic                            wr_en,
    output logic [vhs_pkg::IDX_W-1:0]       wr_addr,
    output logic [vhs_pkg::ACC_W-1:0]       wr_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [vhs_pkg::VOX_W-1:0]       m_out_voxel,
    output logic                            m_out_last
);

    logic                        s1_valid_reg;
    vhs_pkg::cube_info_t         s1_info_reg;
    logic [vhs_pkg::VOX_W-1:0]   s1_voxel_reg;
    logic                        s1_fwd_reg;
    logic [vhs_pkg::ACC_W-1:0]   s1_fwd_data_reg;

    logic                        m_valid_reg;
    logic [vhs_pkg::VOX_W-1:0]   m_voxel_reg;
    logic                        m_last_reg;

    logic [vhs_pkg::ACC_W-1:0]   old_val;
    logic [vhs_pkg::ACC_W:0]     sum;
    logic [vhs_pkg::ACC_W-1:0]   acc;
    logic [vhs_pkg::ACC_W:0]     rnd_sum;
    logic [vhs_pkg::ACC_W-1:0]   res_wide;
    logic [vhs_pkg::VOX_W-1:0]   res;
    logic                        emit;
    logic                        out_free;
    logic                        s1_done;

    always_comb begin
        // Entry written at the edge this item was read comes from the bypass.
        old_val = s1_fwd_reg ? s1_fwd_data_reg : rd_data;
        sum = {1'b0, old_val} + (vhs_pkg::ACC_W+1)'(s1_voxel_reg);
        if (s1_info_reg.first) begin
            acc = vhs_pkg::ACC_W'(s1_voxel_reg);
        end else if (mode_max) begin
            acc = (old_val > vhs_pkg::ACC_W'(s1_voxel_reg))
                ? old_val : vhs_pkg::ACC_W'(s1_voxel_reg);
        end else if (sum > (vhs_pkg::ACC_W+1)'(vhs_pkg::SUM_LIMIT)) begin
            acc = vhs_pkg::ACC_W'(vhs_pkg::SUM_LIMIT);
        end else begin
            acc = sum[vhs_pkg::ACC_W-1:0];
        end

        rnd_sum  = {1'b0, acc} + (vhs_pkg::ACC_W+1)'(4);
        res_wide = mode_max ? acc : vhs_pkg::ACC_W'(rnd_sum >> 3);
        res = (res_wide > vhs_pkg::ACC_W'(255)) ? '1 : res_wide[vhs_pkg::VOX_W-1:0];

        out_free = !m_valid_reg || m_ready;
        emit     = s1_valid_reg && s1_info_reg.act && s1_info_reg.last;
        s1_done  = s1_valid_reg && (!emit || out_free);
        in_ready = !s1_valid_reg || s1_done;

        wr_en   = s1_done && s1_info_reg.act;
        wr_addr = s1_info_reg.idx;
        wr_data = acc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (in_take) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_done) begin
                s1_valid_reg <= 1'b0;
            end
            if (emit && s1_done) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            s1_info_reg     <= in_info;
            s1_voxel_reg    <= in_voxel;
            s1_fwd_reg      <= wr_en && (wr_addr == in_info.idx);
            s1_fwd_data_reg <= acc;
        end
        if (emit && s1_done) begin
            m_voxel_reg <= res;
            m_last_reg  <= s1_info_reg.out_last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_voxel = m_voxel_reg;
    assign m_out_last  = m_last_reg;

endmodule

[rtl/volume_halve_sample_u8.sv]
// Top level of the 2x2x2 volume halving block (mean or max of each cube).
`timescale 1ns / 1ps
// Usage:
//   Voxels enter on the s_ channel (s_valid/s_ready/s_voxel) in raster order:
//   column fastest, then row, plane and channel. Each complete 2x2x2 cube
//   yields one item on the m_ channel (m_valid/m_ready, m_out_voxel,
//   m_out_last); m_out_last marks the final cube of the last channel.
//   Voxels in an odd trailing column, row or plane produce nothing.
//   Registers are written on cfg_we with cfg_index/cfg_wdata, by the user only
//   while the block is idle (the block does not enforce it): 0 mode_max,
//   1 vol_width, 2 vol_height, 3 vol_depth, 4 num_channels.
//   Order: on acceptance the store is read and the voxel is registered in
//   the update stage; that stage then writes the entry back and, for a cube's
//   last voxel, loads the result register that drives m_ once it is free.
//   Throughput: one voxel per cycle unless the output stalls; the store read is
//   issued on acceptance, the write-back when the update stage completes, and
//   a bypass register covers the read that overlaps the write to the same entry.
//   Reset: counters clear and registers return to 0/512/512/2/1. The store
//   is not cleared; a cube's first voxel always overwrites its entry.
//   Stall: while m_ready is low the result register holds, the update stage
//   holds its item and s_ready drops once that stage is blocked.
module volume_halve_sample_u8 (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [vhs_pkg::VOX_W-1:0]         s_voxel,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [vhs_pkg::VOX_W-1:0]         m_out_voxel,
    output logic                              m_out_last,
    input  logic                              cfg_we,
    input  logic [vhs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vhs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    vhs_pkg::cfg_t               cfg_reg;
    vhs_pkg::cube_info_t         info;
    logic                        take;
    logic                        acc_ready;
    logic [vhs_pkg::ACC_W-1:0]   rd_data;
    logic                        wr_en;
    logic [vhs_pkg::IDX_W-1:0]   wr_addr;
    logic [vhs_pkg::ACC_W-1:0]   wr_data;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode_max     <= 1'b0;
            cfg_reg.vol_width    <= vhs_pkg::COL_W'(512);
            cfg_reg.vol_height   <= vhs_pkg::ROW_W'(512);
            cfg_reg.vol_depth    <= vhs_pkg::DEPTH_W'(2);
            cfg_reg.num_channels <= vhs_pkg::NCH_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_index)
                vhs_pkg::REG_MODE_MAX: begin
                    cfg_reg.mode_max <= cfg_wdata[0];
                end
                vhs_pkg::REG_VOL_WIDTH: begin
                    cfg_reg.vol_width <= cfg_wdata[vhs_pkg::COL_W-1:0];
                end
                vhs_pkg::REG_VOL_HEIGHT: begin
                    cfg_reg.vol_height <= cfg_wdata[vhs_pkg::ROW_W-1:0];
                end
                vhs_pkg::REG_VOL_DEPTH: begin
                    cfg_reg.vol_depth <= cfg_wdata[vhs_pkg::DEPTH_W-1:0];
                end
                vhs_pkg::REG_NUM_CHANNELS: begin
                    cfg_reg.num_channels <= cfg_wdata[vhs_pkg::NCH_W-1:0];
                end
                default: begin
                    // unmapped index: ignored
                end
            endcase
        end
    end

    assign s_ready = acc_ready;
    assign take    = s_valid && acc_ready;

    // Position counters; classify the voxel and pick its store entry.
    vhs_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .advance (take),
        .info    (info)
    );

    // Cube store: running sum or max, one entry per cube column/row pair.
    vhs_ram #(
        .WIDTH (vhs_pkg::ACC_W),
        .DEPTH (vhs_pkg::STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (take && info.act),
        .raddr (info.idx),
        .rdata (rd_data)
    );

    // Update stage and result register.
    vhs_accum u_accum (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .mode_max    (cfg_reg.mode_max),
        .in_take     (take),
        .in_info     (info),
        .in_voxel    (s_voxel),
        .in_ready    (acc_ready),
        .rd_data     (rd_data),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_voxel (m_out_voxel),
        .m_out_last  (m_out_last)
    );

endmodule
